/* sv/mlsl_pkg.sv */
// mlsl_pkg: shared types, field widths, register indexes and the microcode
// table of the mip level staging layout unit
// no dependencies
package mlsl_pkg;

   localparam int LVL_W   = 4;
   localparam int OFF_W   = 48;
   localparam int SIZE_W  = 15;
   localparam int DEPTH_W = 12;
   localparam int IMG_W   = 12;
   localparam int ROW_W   = 18;
   localparam int ROWS_W  = 15;

   localparam int TEXEL32_BYTES  = 4;
   localparam int TEXEL64_BYTES  = 8;
   localparam int BLOCK4X4_BYTES = 16;
   localparam int BLOCK_DIM_LOG2 = 2;

   // remainder of the row bytes, three bits per step
   localparam int REM_BITS_PER_STEP = 3;
   localparam int REM_STEPS         = ROW_W / REM_BITS_PER_STEP;
   localparam int REM_CNT_W         = 3;

   typedef enum logic [2:0] {
      CSR_BASE_WIDTH,
      CSR_BASE_HEIGHT,
      CSR_BASE_DEPTH,
      CSR_LAYER_COUNT,
      CSR_IS_VOLUME,
      CSR_FORMAT_CLASS,
      CSR_PAYLOAD_BASE
   } csr_index_type;

   typedef enum logic [1:0] {
      FMT_TEXEL32,
      FMT_TEXEL64,
      FMT_BLOCK4X4,
      FMT_UNSUPPORTED
   } format_type;

   typedef logic [3:0] step_type;

   localparam step_type STEP_IDLE = 4'd0;
   localparam step_type STEP_REM  = 4'd4;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_SIZE,
      OP_MUL_RI,
      OP_MUL_TL,
      OP_REM,
      OP_PITCH,
      OP_MUL_SL,
      OP_SUM,
      OP_END,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_SEQ,
      COND_GOTO,
      COND_WAIT_REQ,
      COND_LOOP_REM,
      COND_WAIT_OUT
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode(input step_type s);
      case (s)
         4'd0: ucode = '{op: OP_IDLE,   cond: COND_WAIT_REQ, target: STEP_IDLE};
         4'd1: ucode = '{op: OP_SIZE,   cond: COND_SEQ,      target: STEP_IDLE};
         4'd2: ucode = '{op: OP_MUL_RI, cond: COND_SEQ,      target: STEP_IDLE};
         4'd3: ucode = '{op: OP_MUL_TL, cond: COND_SEQ,      target: STEP_IDLE};
         4'd4: ucode = '{op: OP_REM,    cond: COND_LOOP_REM, target: STEP_REM};
         4'd5: ucode = '{op: OP_PITCH,  cond: COND_SEQ,      target: STEP_IDLE};
         4'd6: ucode = '{op: OP_MUL_SL, cond: COND_SEQ,      target: STEP_IDLE};
         4'd7: ucode = '{op: OP_SUM,    cond: COND_SEQ,      target: STEP_IDLE};
         4'd8: ucode = '{op: OP_END,    cond: COND_SEQ,      target: STEP_IDLE};
         4'd9: ucode = '{op: OP_EMIT,   cond: COND_WAIT_OUT, target: STEP_IDLE};
         default: ucode = '{op: OP_IDLE, cond: COND_GOTO, target: STEP_IDLE};
      endcase
   endfunction

endpackage

/* sv/mlsl_channels.sv */
// mlsl_req_if and mlsl_rsp_if: valid/ready channels of the staging layout unit
// depends on mlsl_pkg for field widths
interface mlsl_req_if;
   logic                         valid;
   logic                         ready;
   logic [mlsl_pkg::LVL_W-1:0]   mip_level;
   logic [mlsl_pkg::OFF_W-1:0]   level_source_offset;
   logic [mlsl_pkg::OFF_W-1:0]   level_source_length;

   modport source (output valid, mip_level, level_source_offset, level_source_length,
                   input ready);
   modport sink   (input valid, mip_level, level_source_offset, level_source_length,
                   output ready);
endinterface

interface mlsl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [mlsl_pkg::OFF_W-1:0]    source_offset;
   logic [mlsl_pkg::OFF_W-1:0]    staging_offset;
   logic [mlsl_pkg::OFF_W-1:0]    staging_length;
   logic [mlsl_pkg::ROW_W-1:0]    tight_row_bytes;
   logic [mlsl_pkg::ROW_W-1:0]    pitched_row_bytes;
   logic [mlsl_pkg::ROWS_W-1:0]   block_row_count;
   logic [mlsl_pkg::IMG_W-1:0]    image_total;
   logic [mlsl_pkg::SIZE_W-1:0]   level_width;
   logic [mlsl_pkg::SIZE_W-1:0]   level_height;
   logic [mlsl_pkg::DEPTH_W-1:0]  level_depth;

   modport source (output valid, ok, source_offset, staging_offset, staging_length,
                   tight_row_bytes, pitched_row_bytes, block_row_count, image_total,
                   level_width, level_height, level_depth,
                   input ready);
   modport sink   (input valid, ok, source_offset, staging_offset, staging_length,
                   tight_row_bytes, pitched_row_bytes, block_row_count, image_total,
                   level_width, level_height, level_depth,
                   output ready);
endinterface

/* sv/mip_level_staging_layout_unit.sv */
// mip_level_staging_layout_unit: upload footprint of one mip level per transaction
// depends on mlsl_pkg and the channel interfaces in mlsl_channels.sv
//
// One request transaction describes one mip level; one response transaction
// returns its footprint (level sizes, tight and pitched row bytes, block rows,
// image count, source offset, staging offset and length) or ok low with all
// other fields zero. Levels are handled one at a time: a new request is taken
// only after the previous response has been registered, and the final step
// waits while the response side stalls. The work is done by a microcode
// program of ten steps driving one shared 19x27 multiplier (three products)
// and a remainder loop of six steps at three bits per step. A mip level of
// zero restarts the staging cursor; a failed level leaves it alone.
// Configuration writes are taken at any time but belong between levels.
module mip_level_staging_layout_unit #(
   parameter int ALIGNMENT   = 256,
   parameter int MAX_LEVELS  = 16,
   parameter int OFFSET_BITS = 48
) (
   input  logic        clock,
   input  logic        reset,
   mlsl_req_if.sink    req_ch,
   mlsl_rsp_if.source  rsp_ch,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_write_data
);

   localparam int RW = $clog2(ALIGNMENT + 1);
   localparam int AW = RW + 1;
   localparam int XW = 50;
   localparam logic [AW-1:0] ALIGN_V = AW'(ALIGNMENT);
   localparam logic [XW-1:0] LIMIT =
      (OFFSET_BITS >= XW) ? {XW{1'b1}} : ((XW'(1) << OFFSET_BITS) - XW'(1));
   localparam logic [4:0] LEVEL_END = 5'(MAX_LEVELS);

   // configuration
   logic [14:0] base_width_ff, base_width_in;
   logic [14:0] base_height_ff, base_height_in;
   logic [11:0] base_depth_ff, base_depth_in;
   logic [11:0] layer_count_ff, layer_count_in;
   logic        is_volume_ff, is_volume_in;
   mlsl_pkg::format_type format_ff, format_in;
   logic [47:0] payload_base_ff, payload_base_in;

   // sequencer and datapath
   mlsl_pkg::step_type step_ff, step_in;
   mlsl_pkg::ctrl_word_type word;
   logic [3:0]  level_ff, level_in;
   logic [47:0] src_off_ff, src_off_in;
   logic [47:0] src_len_ff, src_len_in;
   logic [14:0] w_ff, w_in;
   logic [14:0] h_ff, h_in;
   logic [11:0] d_ff, d_in;
   logic [14:0] rows_ff, rows_in;
   logic [11:0] images_ff, images_in;
   logic [17:0] tight_ff, tight_in;
   logic [17:0] rsh_ff, rsh_in;
   logic [mlsl_pkg::REM_CNT_W-1:0] rcnt_ff, rcnt_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic        err_ff, err_in;
   logic [26:0] ri_ff, ri_in;
   logic [45:0] prod_ff, prod_in;
   logic [18:0] pitch_ff, pitch_in;
   logic [48:0] start_ff, start_in;
   logic [46:0] slen_ff, slen_in;
   logic [48:0] src_ff, src_in;
   logic [47:0] end_ff, end_in;
   logic [47:0] cursor_ff, cursor_in;
   logic [RW-1:0] cur_rem_ff, cur_rem_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [47:0] rsp_source_offset_ff, rsp_source_offset_in;
   logic [47:0] rsp_staging_offset_ff, rsp_staging_offset_in;
   logic [47:0] rsp_staging_length_ff, rsp_staging_length_in;
   logic [17:0] rsp_tight_ff, rsp_tight_in;
   logic [17:0] rsp_pitch_ff, rsp_pitch_in;
   logic [14:0] rsp_rows_ff, rsp_rows_in;
   logic [11:0] rsp_images_ff, rsp_images_in;
   logic [14:0] rsp_width_ff, rsp_width_in;
   logic [14:0] rsp_height_ff, rsp_height_in;
   logic [11:0] rsp_depth_ff, rsp_depth_in;

   logic        req_accept;
   logic        out_free;
   logic [18:0] mul_a;
   logic [26:0] mul_b;
   logic [45:0] mul_p;

   assign word       = mlsl_pkg::ucode(step_ff);
   assign req_ch.ready = (word.cond == mlsl_pkg::COND_WAIT_REQ);
   assign req_accept = req_ch.valid && req_ch.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.ok                = rsp_ok_ff;
   assign rsp_ch.source_offset     = rsp_source_offset_ff;
   assign rsp_ch.staging_offset    = rsp_staging_offset_ff;
   assign rsp_ch.staging_length    = rsp_staging_length_ff;
   assign rsp_ch.tight_row_bytes   = rsp_tight_ff;
   assign rsp_ch.pitched_row_bytes = rsp_pitch_ff;
   assign rsp_ch.block_row_count   = rsp_rows_ff;
   assign rsp_ch.image_total       = rsp_images_ff;
   assign rsp_ch.level_width       = rsp_width_ff;
   assign rsp_ch.level_height      = rsp_height_ff;
   assign rsp_ch.level_depth       = rsp_depth_ff;

   // configuration writes
   always_comb begin
      base_width_in   = base_width_ff;
      base_height_in  = base_height_ff;
      base_depth_in   = base_depth_ff;
      layer_count_in  = layer_count_ff;
      is_volume_in    = is_volume_ff;
      format_in       = format_ff;
      payload_base_in = payload_base_ff;
      if (csr_write_enable) begin
         case (mlsl_pkg::csr_index_type'(csr_index))
            mlsl_pkg::CSR_BASE_WIDTH:   base_width_in   = csr_write_data[14:0];
            mlsl_pkg::CSR_BASE_HEIGHT:  base_height_in  = csr_write_data[14:0];
            mlsl_pkg::CSR_BASE_DEPTH:   base_depth_in   = csr_write_data[11:0];
            mlsl_pkg::CSR_LAYER_COUNT:  layer_count_in  = csr_write_data[11:0];
            mlsl_pkg::CSR_IS_VOLUME:    is_volume_in    = csr_write_data[0];
            mlsl_pkg::CSR_FORMAT_CLASS: format_in = mlsl_pkg::format_type'(csr_write_data[1:0]);
            mlsl_pkg::CSR_PAYLOAD_BASE: payload_base_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // shared multiplier
   always_comb begin
      case (word.op)
         mlsl_pkg::OP_MUL_RI: begin
            mul_a = 19'(rows_ff);
            mul_b = 27'(images_ff);
         end
         mlsl_pkg::OP_MUL_TL: begin
            mul_a = 19'(tight_ff);
            mul_b = ri_ff;
         end
         mlsl_pkg::OP_MUL_SL: begin
            mul_a = pitch_ff;
            mul_b = ri_ff - 27'd1;
         end
         default: begin
            mul_a = 19'd0;
            mul_b = 27'd0;
         end
      endcase
   end

   assign mul_p = 46'(mul_a) * 46'(mul_b);

   // datapath and step sequencing
   always_comb begin
      logic [14:0] w_sh, h_sh, w_lvl, h_lvl;
      logic [11:0] d_sh, d_lvl;
      logic [14:0] wide;
      logic [11:0] img;
      logic        bad;
      logic [RW-1:0] rem_t;
      logic [AW-1:0] cand;
      logic [18:0] pitch_calc;
      logic [48:0] start_calc;
      logic [XW-1:0] end_calc;

      w_sh = base_width_ff >> level_ff;
      h_sh = base_height_ff >> level_ff;
      d_sh = base_depth_ff >> level_ff;
      w_lvl = (w_sh == 15'd0) ? 15'd1 : w_sh;
      h_lvl = (h_sh == 15'd0) ? 15'd1 : h_sh;
      d_lvl = (d_sh == 12'd0) ? 12'd1 : d_sh;
      img = is_volume_ff ? d_lvl : layer_count_ff;
      bad = ({1'b0, level_ff} >= LEVEL_END) || (img == 12'd0);

      rem_t = rem_ff;
      for (int i = 0; i < mlsl_pkg::REM_BITS_PER_STEP; i++) begin
         cand = {rem_t, rsh_ff[17-i]};
         if (cand >= ALIGN_V) rem_t = RW'(cand - ALIGN_V);
         else                 rem_t = RW'(cand);
      end

      pitch_calc = 19'(tight_ff) - 19'(rem_ff) + ((rem_ff != '0) ? 19'(ALIGNMENT) : 19'd0);
      start_calc = 49'(cursor_ff) - 49'(cur_rem_ff)
                 + ((cur_rem_ff != '0) ? 49'(ALIGNMENT) : 49'd0);
      end_calc   = XW'(start_ff) + XW'(slen_ff);

      step_in    = step_ff;
      level_in   = level_ff;
      src_off_in = src_off_ff;
      src_len_in = src_len_ff;
      w_in       = w_ff;
      h_in       = h_ff;
      d_in       = d_ff;
      rows_in    = rows_ff;
      images_in  = images_ff;
      tight_in   = tight_ff;
      rsh_in     = rsh_ff;
      rcnt_in    = rcnt_ff;
      rem_in     = rem_ff;
      err_in     = err_ff;
      ri_in      = ri_ff;
      prod_in    = prod_ff;
      pitch_in   = pitch_ff;
      start_in   = start_ff;
      slen_in    = slen_ff;
      src_in     = src_ff;
      end_in     = end_ff;
      cursor_in  = cursor_ff;
      cur_rem_in = cur_rem_ff;

      rsp_valid_in          = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in             = rsp_ok_ff;
      rsp_source_offset_in  = rsp_source_offset_ff;
      rsp_staging_offset_in = rsp_staging_offset_ff;
      rsp_staging_length_in = rsp_staging_length_ff;
      rsp_tight_in          = rsp_tight_ff;
      rsp_pitch_in          = rsp_pitch_ff;
      rsp_rows_in           = rsp_rows_ff;
      rsp_images_in         = rsp_images_ff;
      rsp_width_in          = rsp_width_ff;
      rsp_height_in         = rsp_height_ff;
      rsp_depth_in          = rsp_depth_ff;

      case (word.op)
         mlsl_pkg::OP_IDLE: begin
            if (req_accept) begin
               level_in   = req_ch.mip_level;
               src_off_in = req_ch.level_source_offset;
               src_len_in = req_ch.level_source_length;
               if (req_ch.mip_level == 4'd0) begin
                  cursor_in  = 48'd0;
                  cur_rem_in = '0;
               end
            end
         end
         mlsl_pkg::OP_SIZE: begin
            w_in      = w_lvl;
            h_in      = h_lvl;
            d_in      = d_lvl;
            images_in = img;
            rcnt_in   = '0;
            rem_in    = '0;
            case (format_ff)
               mlsl_pkg::FMT_TEXEL32: begin
                  wide     = w_lvl;
                  rows_in  = h_lvl;
                  tight_in = 18'(wide) * 18'(mlsl_pkg::TEXEL32_BYTES);
                  err_in   = bad;
               end
               mlsl_pkg::FMT_TEXEL64: begin
                  wide     = w_lvl;
                  rows_in  = h_lvl;
                  tight_in = 18'(wide) * 18'(mlsl_pkg::TEXEL64_BYTES);
                  err_in   = bad;
               end
               mlsl_pkg::FMT_BLOCK4X4: begin
                  wide     = 15'((16'(w_lvl) + 16'd3) >> mlsl_pkg::BLOCK_DIM_LOG2);
                  rows_in  = 15'((16'(h_lvl) + 16'd3) >> mlsl_pkg::BLOCK_DIM_LOG2);
                  tight_in = 18'(wide) * 18'(mlsl_pkg::BLOCK4X4_BYTES);
                  err_in   = bad;
               end
               default: begin
                  wide     = w_lvl;
                  rows_in  = h_lvl;
                  tight_in = 18'd0;
                  err_in   = 1'b1;
               end
            endcase
            rsh_in = tight_in;
         end
         mlsl_pkg::OP_MUL_RI: ri_in = mul_p[26:0];
         mlsl_pkg::OP_MUL_TL: prod_in = mul_p;
         mlsl_pkg::OP_REM: begin
            rem_in  = rem_t;
            rsh_in  = rsh_ff << mlsl_pkg::REM_BITS_PER_STEP;
            rcnt_in = rcnt_ff + 1'b1;
         end
         mlsl_pkg::OP_PITCH: begin
            pitch_in = pitch_calc;
            start_in = start_calc;
            if ({2'b00, prod_ff} != src_len_ff || pitch_calc[18]) err_in = 1'b1;
         end
         mlsl_pkg::OP_MUL_SL: prod_in = mul_p;
         mlsl_pkg::OP_SUM: begin
            slen_in = 47'(prod_ff) + 47'(tight_ff);
            src_in  = 49'(payload_base_ff) + 49'(src_off_ff);
         end
         mlsl_pkg::OP_END: begin
            end_in = end_calc[47:0];
            if (end_calc > LIMIT || XW'(src_ff) > LIMIT) err_in = 1'b1;
         end
         mlsl_pkg::OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = !err_ff;
               if (err_ff) begin
                  rsp_source_offset_in  = 48'd0;
                  rsp_staging_offset_in = 48'd0;
                  rsp_staging_length_in = 48'd0;
                  rsp_tight_in          = 18'd0;
                  rsp_pitch_in          = 18'd0;
                  rsp_rows_in           = 15'd0;
                  rsp_images_in         = 12'd0;
                  rsp_width_in          = 15'd0;
                  rsp_height_in         = 15'd0;
                  rsp_depth_in          = 12'd0;
               end else begin
                  rsp_source_offset_in  = src_ff[47:0];
                  rsp_staging_offset_in = start_ff[47:0];
                  rsp_staging_length_in = 48'(slen_ff);
                  rsp_tight_in          = tight_ff;
                  rsp_pitch_in          = pitch_ff[17:0];
                  rsp_rows_in           = rows_ff;
                  rsp_images_in         = images_ff;
                  rsp_width_in          = w_ff;
                  rsp_height_in         = h_ff;
                  rsp_depth_in          = d_ff;
                  cursor_in             = end_ff;
                  cur_rem_in            = rem_ff;
               end
            end
         end
         default: ;
      endcase

      case (word.cond)
         mlsl_pkg::COND_SEQ:      step_in = step_ff + 1'b1;
         mlsl_pkg::COND_GOTO:     step_in = word.target;
         mlsl_pkg::COND_WAIT_REQ: step_in = req_accept ? step_ff + 1'b1 : step_ff;
         mlsl_pkg::COND_LOOP_REM:
            step_in = (rcnt_ff != mlsl_pkg::REM_CNT_W'(mlsl_pkg::REM_STEPS - 1))
                    ? word.target : step_ff + 1'b1;
         mlsl_pkg::COND_WAIT_OUT: step_in = out_free ? word.target : step_ff;
         default:                 step_in = mlsl_pkg::STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_width_ff   <= 15'd1;
         base_height_ff  <= 15'd1;
         base_depth_ff   <= 12'd1;
         layer_count_ff  <= 12'd1;
         is_volume_ff    <= 1'b0;
         format_ff       <= mlsl_pkg::FMT_TEXEL32;
         payload_base_ff <= 48'd0;
         step_ff         <= mlsl_pkg::STEP_IDLE;
         cursor_ff       <= 48'd0;
         cur_rem_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         base_width_ff   <= base_width_in;
         base_height_ff  <= base_height_in;
         base_depth_ff   <= base_depth_in;
         layer_count_ff  <= layer_count_in;
         is_volume_ff    <= is_volume_in;
         format_ff       <= format_in;
         payload_base_ff <= payload_base_in;
         step_ff         <= step_in;
         cursor_ff       <= cursor_in;
         cur_rem_ff      <= cur_rem_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff   <= level_in;
      src_off_ff <= src_off_in;
      src_len_ff <= src_len_in;
      w_ff       <= w_in;
      h_ff       <= h_in;
      d_ff       <= d_in;
      rows_ff    <= rows_in;
      images_ff  <= images_in;
      tight_ff   <= tight_in;
      rsh_ff     <= rsh_in;
      rcnt_ff    <= rcnt_in;
      rem_ff     <= rem_in;
      err_ff     <= err_in;
      ri_ff      <= ri_in;
      prod_ff    <= prod_in;
      pitch_ff   <= pitch_in;
      start_ff   <= start_in;
      slen_ff    <= slen_in;
      src_ff     <= src_in;
      end_ff     <= end_in;
      rsp_ok_ff             <= rsp_ok_in;
      rsp_source_offset_ff  <= rsp_source_offset_in;
      rsp_staging_offset_ff <= rsp_staging_offset_in;
      rsp_staging_length_ff <= rsp_staging_length_in;
      rsp_tight_ff          <= rsp_tight_in;
      rsp_pitch_ff          <= rsp_pitch_in;
      rsp_rows_ff           <= rsp_rows_in;
      rsp_images_ff         <= rsp_images_in;
      rsp_width_ff          <= rsp_width_in;
      rsp_height_ff         <= rsp_height_in;
      rsp_depth_ff          <= rsp_depth_in;
   end

`ifndef SYNTH
   a_accept_starts_program: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> word.op == mlsl_pkg::OP_SIZE)
      else $error("accepted transaction did not start the size step");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(word.op == mlsl_pkg::OP_EMIT))
      else $error("response raised outside the emit step");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |->
         rsp_staging_length_ff == 48'd0 && rsp_source_offset_ff == 48'd0)
      else $error("failed level carries nonzero fields");

   a_cursor_rem_range: assert property (@(posedge clock) disable iff (reset)
      AW'(cur_rem_ff) < ALIGN_V)
      else $error("cursor remainder not below alignment");

   a_rem_loop_bound: assert property (@(posedge clock) disable iff (reset)
      word.op == mlsl_pkg::OP_REM |->
         rcnt_ff < mlsl_pkg::REM_CNT_W'(mlsl_pkg::REM_STEPS))
      else $error("remainder loop ran past its step count");
`endif

endmodule

/* tb/sv/mlsl_footprint_checker.sv */
`timescale 1ns / 1ps
// mlsl_footprint_checker: watches the request, response and register ports of the
// mip level staging layout unit, predicts each level footprint and compares it
// depends on mlsl_pkg and the channel interfaces in mlsl_channels.sv
module mlsl_footprint_checker
   import mlsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mlsl_req_if         req_ch,
   mlsl_rsp_if         rsp_ch,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_write_data,
   output int unsigned mismatch_count,
   output int unsigned pending_count
);

   localparam logic [63:0] PITCH_ALIGN  = 64'd256;
   localparam int          LEVEL_COUNT  = 16;
   localparam logic [63:0] ROW_LIMIT    = 64'h3_FFFF;
   localparam logic [63:0] OFFSET_LIMIT = (64'd1 << OFF_W) - 64'd1;
   localparam logic [63:0] BLOCK_EDGE   = 64'd1 << BLOCK_DIM_LOG2;

   typedef struct packed {
      logic                 ok;
      logic [OFF_W-1:0]     source_offset;
      logic [OFF_W-1:0]     staging_offset;
      logic [OFF_W-1:0]     staging_length;
      logic [ROW_W-1:0]     tight_row_bytes;
      logic [ROW_W-1:0]     pitched_row_bytes;
      logic [ROWS_W-1:0]    block_row_count;
      logic [IMG_W-1:0]     image_total;
      logic [SIZE_W-1:0]    level_width;
      logic [SIZE_W-1:0]    level_height;
      logic [DEPTH_W-1:0]   level_depth;
   } footprint_t;

   logic [SIZE_W-1:0]  base_width;
   logic [SIZE_W-1:0]  base_height;
   logic [DEPTH_W-1:0] base_depth;
   logic [IMG_W-1:0]   layer_count;
   logic               is_volume;
   format_type         fmt_class;
   logic [OFF_W-1:0]   payload_base;
   logic [OFF_W-1:0]   staging_cursor;

   footprint_t  expected_footprints[$];
   int unsigned response_index;

   function automatic logic [63:0] shrink_dim(input logic [63:0] size, input logic [3:0] lvl);
      logic [63:0] v;
      v = size >> lvl;
      return (v == 64'd0) ? 64'd1 : v;
   endfunction

   function automatic logic [63:0] round_to_pitch(input logic [63:0] v);
      return ((v + PITCH_ALIGN - 64'd1) / PITCH_ALIGN) * PITCH_ALIGN;
   endfunction

   // failed levels return all zero and leave the cursor alone
   function automatic footprint_t predict_footprint(input logic [3:0] lvl,
                                                    input logic [OFF_W-1:0] rel_off,
                                                    input logic [OFF_W-1:0] declared_len);
      footprint_t  fp;
      logic [63:0] w, h, d, wide, rows, images, bpb, tight, pitch, start, slen, src;
      fp = '0;
      if (lvl == 4'd0) staging_cursor = '0;
      w = shrink_dim(64'(base_width), lvl);
      h = shrink_dim(64'(base_height), lvl);
      d = shrink_dim(64'(base_depth), lvl);
      case (fmt_class)
         FMT_TEXEL32: begin
            wide = w;
            rows = h;
            bpb  = 64'(TEXEL32_BYTES);
         end
         FMT_TEXEL64: begin
            wide = w;
            rows = h;
            bpb  = 64'(TEXEL64_BYTES);
         end
         FMT_BLOCK4X4: begin
            wide = (w + BLOCK_EDGE - 64'd1) / BLOCK_EDGE;
            rows = (h + BLOCK_EDGE - 64'd1) / BLOCK_EDGE;
            bpb  = 64'(BLOCK4X4_BYTES);
         end
         default: return fp;
      endcase
      if (int'(lvl) >= LEVEL_COUNT) return fp;
      images = is_volume ? d : 64'(layer_count);
      if (images == 64'd0) return fp;
      tight = wide * bpb;
      if (tight * rows * images != 64'(declared_len) || tight > ROW_LIMIT) return fp;
      pitch = round_to_pitch(tight);
      if (pitch > ROW_LIMIT) return fp;
      start = round_to_pitch(64'(staging_cursor));
      if (start > OFFSET_LIMIT) return fp;
      slen = pitch * rows * (images - 64'd1) + pitch * (rows - 64'd1) + tight;
      if (slen > OFFSET_LIMIT || start > OFFSET_LIMIT - slen) return fp;
      src = 64'(payload_base) + 64'(rel_off);
      if (src > OFFSET_LIMIT) return fp;
      staging_cursor = OFF_W'(start + slen);
      fp.ok                = 1'b1;
      fp.source_offset     = OFF_W'(src);
      fp.staging_offset    = OFF_W'(start);
      fp.staging_length    = OFF_W'(slen);
      fp.tight_row_bytes   = ROW_W'(tight);
      fp.pitched_row_bytes = ROW_W'(pitch);
      fp.block_row_count   = ROWS_W'(rows);
      fp.image_total       = IMG_W'(images);
      fp.level_width       = SIZE_W'(w);
      fp.level_height      = SIZE_W'(h);
      fp.level_depth       = DEPTH_W'(d);
      return fp;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] staging layout mismatch, response %0d: %s", $time, response_index, what);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] seen);
      if (seen !== want)
         report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, seen));
   endtask

   task automatic compare_response();
      footprint_t want;
      response_index++;
      if (expected_footprints.size() == 0) begin
         report_mismatch("response transaction with no level outstanding");
         return;
      end
      want = expected_footprints.pop_front();
      check_field("ok", want.ok, rsp_ch.ok);
      check_field("source_offset", want.source_offset, rsp_ch.source_offset);
      check_field("staging_offset", want.staging_offset, rsp_ch.staging_offset);
      check_field("staging_length", want.staging_length, rsp_ch.staging_length);
      check_field("tight_row_bytes", want.tight_row_bytes, rsp_ch.tight_row_bytes);
      check_field("pitched_row_bytes", want.pitched_row_bytes, rsp_ch.pitched_row_bytes);
      check_field("block_row_count", want.block_row_count, rsp_ch.block_row_count);
      check_field("image_total", want.image_total, rsp_ch.image_total);
      check_field("level_width", want.level_width, rsp_ch.level_width);
      check_field("level_height", want.level_height, rsp_ch.level_height);
      check_field("level_depth", want.level_depth, rsp_ch.level_depth);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         base_width     = SIZE_W'(1);
         base_height    = SIZE_W'(1);
         base_depth     = DEPTH_W'(1);
         layer_count    = IMG_W'(1);
         is_volume      = 1'b0;
         fmt_class      = FMT_TEXEL32;
         payload_base   = '0;
         staging_cursor = '0;
         expected_footprints.delete();
         pending_count <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) compare_response();
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_BASE_WIDTH:   base_width   = csr_write_data[SIZE_W-1:0];
               CSR_BASE_HEIGHT:  base_height  = csr_write_data[SIZE_W-1:0];
               CSR_BASE_DEPTH:   base_depth   = csr_write_data[DEPTH_W-1:0];
               CSR_LAYER_COUNT:  layer_count  = csr_write_data[IMG_W-1:0];
               CSR_IS_VOLUME:    is_volume    = csr_write_data[0];
               CSR_FORMAT_CLASS: fmt_class    = format_type'(csr_write_data[1:0]);
               CSR_PAYLOAD_BASE: payload_base = csr_write_data[OFF_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            expected_footprints.push_back(predict_footprint(req_ch.mip_level,
               req_ch.level_source_offset, req_ch.level_source_length));
         pending_count <= expected_footprints.size();
      end
   end

endmodule

/* tb/sv/tb_mip_level_staging_layout_unit.sv */
`timescale 1ns / 1ps
// tb_mip_level_staging_layout_unit: drives directed and random mip level chains with
// random bursts, response stalls and register settings, and gives the verdict
// depends on mlsl_pkg, mlsl_channels.sv, mlsl_footprint_checker and the unit itself
module tb_mip_level_staging_layout_unit;
   import mlsl_pkg::*;

   localparam int unsigned ITEM_TARGET   = 1850;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam logic [OFF_W-1:0] OFFSET_MAX = '1;

   typedef enum int unsigned {STALL_NONE, STALL_COIN, STALL_LONG} stall_mode_t;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [47:0] csr_write_data;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned items_sent;
   int unsigned burst_left;
   int unsigned cycle_count;

   // settings as last written
   logic [SIZE_W-1:0]  cfg_width   = SIZE_W'(1);
   logic [SIZE_W-1:0]  cfg_height  = SIZE_W'(1);
   logic [DEPTH_W-1:0] cfg_depth   = DEPTH_W'(1);
   logic [IMG_W-1:0]   cfg_layers  = IMG_W'(1);
   logic               cfg_volume  = 1'b0;
   format_type         cfg_format  = FMT_TEXEL32;
   logic [OFF_W-1:0]   cfg_payload = '0;

   mlsl_req_if req_ch ();
   mlsl_rsp_if rsp_ch ();

   mip_level_staging_layout_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   mlsl_footprint_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("mip_level_staging_layout_unit regression: fail");
            $finish;
         end
      end
   end

   initial begin : rsp_backpressure
      stall_mode_t mode;
      int unsigned mode_left;
      int unsigned stall_left;
      rsp_ch.ready <= 1'b0;
      mode       = STALL_NONE;
      mode_left  = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = stall_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         case (mode)
            STALL_NONE: rsp_ch.ready <= 1'b1;
            STALL_COIN: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_ch.ready <= 1'b0;
               end else begin
                  rsp_ch.ready <= 1'b1;
                  if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 24);
               end
            end
         endcase
      end
   end

   function automatic logic [OFF_W-1:0] rand48();
      return {16'($urandom), $urandom};
   endfunction

   // declared length that matches the current settings
   function automatic logic [OFF_W-1:0] level_length(input logic [3:0] lvl);
      logic [63:0] w, h, d, tight, rows, images;
      w = 64'(cfg_width) >> lvl;
      h = 64'(cfg_height) >> lvl;
      d = 64'(cfg_depth) >> lvl;
      if (w == 64'd0) w = 64'd1;
      if (h == 64'd0) h = 64'd1;
      if (d == 64'd0) d = 64'd1;
      case (cfg_format)
         FMT_TEXEL32: begin
            tight = w * 64'(TEXEL32_BYTES);
            rows  = h;
         end
         FMT_TEXEL64: begin
            tight = w * 64'(TEXEL64_BYTES);
            rows  = h;
         end
         FMT_BLOCK4X4: begin
            tight = ((w + 64'd3) >> BLOCK_DIM_LOG2) * 64'(BLOCK4X4_BYTES);
            rows  = (h + 64'd3) >> BLOCK_DIM_LOG2;
         end
         default: return '0;
      endcase
      images = cfg_volume ? d : 64'(cfg_layers);
      return OFF_W'(tight * rows * images);
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return SIZE_W'($urandom_range(1, 64));
      if (roll < 75) return SIZE_W'($urandom_range(1, 4096));
      if (roll < 90) return SIZE_W'($urandom);
      case ($urandom_range(0, 3))
         0: return SIZE_W'(0);
         1: return SIZE_W'(1);
         2: return SIZE_W'(16384);
         default: return '1;
      endcase
   endfunction

   function automatic logic [IMG_W-1:0] pick_count();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return IMG_W'($urandom_range(1, 8));
      if (roll < 80) return IMG_W'($urandom_range(1, 64));
      if (roll < 90) return IMG_W'($urandom);
      case ($urandom_range(0, 3))
         0: return IMG_W'(0);
         1: return IMG_W'(1);
         2: return IMG_W'(2048);
         default: return '1;
      endcase
   endfunction

   function automatic logic [OFF_W-1:0] pick_offset();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return OFF_W'($urandom_range(0, 1 << 20));
      if (roll < 85) return rand48();
      return OFFSET_MAX - OFF_W'($urandom_range(0, 4096));
   endfunction

   task automatic send_level(input logic [3:0] lvl, input logic [OFF_W-1:0] rel_off,
                             input logic [OFF_W-1:0] declared_len);
      req_ch.valid               <= 1'b1;
      req_ch.mip_level           <= lvl;
      req_ch.level_source_offset <= rel_off;
      req_ch.level_source_length <= declared_len;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input logic [SIZE_W-1:0] width, input logic [SIZE_W-1:0] height,
                              input logic [DEPTH_W-1:0] depth, input logic [IMG_W-1:0] layers,
                              input logic volume, input format_type fmt,
                              input logic [OFF_W-1:0] payload);
      logic [47:0] vals [0:6];
      drain_results();
      cfg_width   = width;
      cfg_height  = height;
      cfg_depth   = depth;
      cfg_layers  = layers;
      cfg_volume  = volume;
      cfg_format  = fmt;
      cfg_payload = payload;
      vals[CSR_BASE_WIDTH]   = 48'(width);
      vals[CSR_BASE_HEIGHT]  = 48'(height);
      vals[CSR_BASE_DEPTH]   = 48'(depth);
      vals[CSR_LAYER_COUNT]  = 48'(layers);
      vals[CSR_IS_VOLUME]    = 48'(volume);
      vals[CSR_FORMAT_CLASS] = 48'(fmt);
      vals[CSR_PAYLOAD_BASE] = payload;
      for (int i = 0; i <= int'(CSR_PAYLOAD_BASE); i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= 3'(i);
         csr_write_data   <= vals[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // mostly ascending level chains with the right lengths, some noise
   task automatic random_phase(input int unsigned count);
      logic [3:0]       lvl;
      logic [3:0]       chain_next;
      logic [OFF_W-1:0] declared_len;
      chain_next = 4'd0;
      for (int unsigned n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 85) begin
            lvl          = chain_next;
            chain_next   = (lvl == 4'd15 || $urandom_range(0, 5) == 0) ? 4'd0 : lvl + 4'd1;
            declared_len = level_length(lvl);
            if ($urandom_range(0, 9) == 0)
               declared_len = ($urandom_range(0, 1) == 1) ? declared_len + 1'b1
                                                          : declared_len - 1'b1;
         end else begin
            lvl          = 4'($urandom_range(0, 15));
            declared_len = ($urandom_range(0, 1) == 1) ? rand48() : level_length(lvl);
         end
         send_level(lvl, pick_offset(), declared_len);
         if ($urandom_range(0, 99) < 3) drain_results();
      end
   endtask

   initial begin : stimulus
      format_type fmt;
      logic [OFF_W-1:0] payload;
      int unsigned roll;
      reset                      <= 1'b1;
      csr_write_enable           <= 1'b0;
      csr_index                  <= 3'(CSR_BASE_WIDTH);
      csr_write_data             <= '0;
      req_ch.valid               <= 1'b0;
      req_ch.mip_level           <= '0;
      req_ch.level_source_offset <= '0;
      req_ch.level_source_length <= '0;
      items_sent = 0;
      burst_left = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // settings after reset: a single texel
      send_level(4'd0, '0, level_length(4'd0));
      send_level(4'd15, OFFSET_MAX, level_length(4'd15));
      send_level(4'd1, '0, OFFSET_MAX);
      send_level(4'd0, '0, '0);

      // widest row: pitch overflows at level zero only
      load_config('1, SIZE_W'(3), DEPTH_W'(1), IMG_W'(2), 1'b0, FMT_TEXEL64, '0);
      send_level(4'd0, '0, level_length(4'd0));
      send_level(4'd1, '0, level_length(4'd1));
      send_level(4'd2, OFF_W'(48'h1234), level_length(4'd2));

      // largest volume of blocks
      load_config(SIZE_W'(16384), SIZE_W'(16384), DEPTH_W'(2048), IMG_W'(2048), 1'b1,
                  FMT_BLOCK4X4, '0);
      send_level(4'd0, '0, level_length(4'd0));
      send_level(4'd15, '0, level_length(4'd15));

      // zero sizes, no layers
      load_config('0, '0, '0, '0, 1'b0, FMT_BLOCK4X4, '0);
      send_level(4'd0, '0, level_length(4'd0));
      load_config('0, '0, '0, '0, 1'b1, FMT_BLOCK4X4, '0);
      send_level(4'd0, '0, level_length(4'd0));
      send_level(4'd1, '0, level_length(4'd1));

      // unsupported format
      load_config(SIZE_W'(5), SIZE_W'(7), DEPTH_W'(1), IMG_W'(3), 1'b0, FMT_UNSUPPORTED, '0);
      send_level(4'd0, '0, '0);
      send_level(4'd3, '0, OFF_W'(48'd60));

      // source offset at and past the top
      load_config(SIZE_W'(1), SIZE_W'(1), DEPTH_W'(1), IMG_W'(1), 1'b0, FMT_TEXEL32, OFFSET_MAX);
      send_level(4'd0, '0, level_length(4'd0));
      send_level(4'd1, OFF_W'(1), level_length(4'd1));
      send_level(4'd2, OFFSET_MAX, level_length(4'd2));

      // staging cursor runs past the offset range
      load_config('1, '1, DEPTH_W'(1), '1, 1'b0, FMT_TEXEL64, '0);
      send_level(4'd0, '0, level_length(4'd0));
      for (int n = 0; n < 40; n++) send_level(4'd1, pick_offset(), level_length(4'd1));

      while (items_sent < ITEM_TARGET) begin
         roll    = $urandom_range(0, 99);
         fmt     = (roll < 8) ? FMT_UNSUPPORTED : format_type'($urandom_range(0, 2));
         roll    = $urandom_range(0, 99);
         payload = (roll < 50) ? OFF_W'($urandom_range(0, 1 << 20)) :
                   (roll < 80) ? rand48() : OFFSET_MAX - OFF_W'($urandom_range(0, 4096));
         load_config(pick_size(), pick_size(), pick_count(), pick_count(),
                     1'($urandom_range(0, 1)), fmt, payload);
         random_phase($urandom_range(10, 60));
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("mip_level_staging_layout_unit regression: pass");
      end else begin
         $display("mip_level_staging_layout_unit regression: fail");
      end
      $finish;
   end

endmodule
